@@ rtl/vms_pkg.sv @@
// ----------------------------------------------------------------------------
// vms_pkg
// Shared types and codes for the video mode switch register block.
// ----------------------------------------------------------------------------
package vms_pkg;

  // Access kinds carried in the mode field of a request.
  localparam logic [5:0] ACC_CLR80COL  = 6'd0;
  localparam logic [5:0] ACC_SET80COL  = 6'd1;
  localparam logic [5:0] ACC_RD80COL   = 6'd2;
  localparam logic [5:0] ACC_CLRALTCH  = 6'd3;
  localparam logic [5:0] ACC_SETALTCH  = 6'd4;
  localparam logic [5:0] ACC_RDALTCH   = 6'd5;
  localparam logic [5:0] ACC_RDCOLOR   = 6'd6;
  localparam logic [5:0] ACC_WRCOLOR   = 6'd7;
  localparam logic [5:0] ACC_RDINTREG  = 6'd8;
  localparam logic [5:0] ACC_WRINTREG  = 6'd9;
  localparam logic [5:0] ACC_CLRINT    = 6'd10;
  localparam logic [5:0] ACC_RDNEWVID  = 6'd11;
  localparam logic [5:0] ACC_WRNEWVID  = 6'd12;
  localparam logic [5:0] ACC_RDVERTCNT = 6'd13;
  localparam logic [5:0] ACC_RDHORZCNT = 6'd14;
  localparam logic [5:0] ACC_RDBORDER  = 6'd15;
  localparam logic [5:0] ACC_WRBORDER  = 6'd16;
  localparam logic [5:0] ACC_CLRTEXT   = 6'd17;
  localparam logic [5:0] ACC_SETTEXT   = 6'd18;
  localparam logic [5:0] ACC_RDTEXT    = 6'd19;
  localparam logic [5:0] ACC_CLRMIXED  = 6'd20;
  localparam logic [5:0] ACC_SETMIXED  = 6'd21;
  localparam logic [5:0] ACC_RDMIXED   = 6'd22;
  localparam logic [5:0] ACC_CLRPAGE2  = 6'd23;
  localparam logic [5:0] ACC_SETPAGE2  = 6'd24;
  localparam logic [5:0] ACC_RDPAGE2   = 6'd25;
  localparam logic [5:0] ACC_CLRHIRES  = 6'd26;
  localparam logic [5:0] ACC_SETHIRES  = 6'd27;
  localparam logic [5:0] ACC_RDHIRES   = 6'd28;
  localparam logic [5:0] ACC_CLRDBLRES = 6'd29;
  localparam logic [5:0] ACC_SETDBLRES = 6'd30;
  localparam logic [5:0] ACC_VIDRESET  = 6'd31;
  localparam logic [5:0] ACC_REDRAW    = 6'd32;

  // Display modes.
  localparam logic [3:0] DM_40TEXT1 = 4'd0;
  localparam logic [3:0] DM_80TEXT1 = 4'd2;
  localparam logic [3:0] DM_LORES1  = 4'd4;
  localparam logic [3:0] DM_DLORES1 = 4'd6;
  localparam logic [3:0] DM_HIRES1  = 4'd8;
  localparam logic [3:0] DM_HIRES2  = 4'd9;
  localparam logic [3:0] DM_DHIRES1 = 4'd10;
  localparam logic [3:0] DM_DHIRES2 = 4'd11;
  localparam logic [3:0] DM_SUPER   = 4'd12;

  // Page move codes.
  localparam logic [2:0] PM_NONE     = 3'd0;
  localparam logic [2:0] PM_HI_1TO2  = 3'd1;
  localparam logic [2:0] PM_HI_2TO1  = 3'd2;
  localparam logic [2:0] PM_DHI_1TO2 = 3'd3;
  localparam logic [2:0] PM_DHI_2TO1 = 3'd4;

  // Geometry change codes.
  localparam logic [1:0] GC_NONE     = 2'd0;
  localparam logic [1:0] GC_TO_SUPER = 2'd1;
  localparam logic [1:0] GC_TO_STD   = 2'd2;

  // Display switch bit positions.
  localparam int SW_80COL  = 0;
  localparam int SW_ALTCH  = 1;
  localparam int SW_TEXT   = 2;
  localparam int SW_MIXED  = 3;
  localparam int SW_PAGE2  = 4;
  localparam int SW_HIRES  = 5;
  localparam int SW_DBLRES = 6;

  // New-video bit positions.
  localparam int NV_MONO   = 0;
  localparam int NV_LINEAR = 1;
  localparam int NV_SUPER  = 2;

  // Offset added to the vertical count on a read.
  localparam logic [9:0] VERT_OFFSET = 10'h0FA;

  typedef struct packed {
    logic [5:0] mode;
    logic [7:0] write_data;
    logic       store80;
    logic [8:0] vert_count;
    logic [6:0] horiz_sample;
    logic [1:0] irq_events;
  } vms_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] display_mode;
    logic [2:0] page_move;
    logic       full_redraw;
    logic [1:0] geometry_change;
    logic [1:0] irq_acks;
    logic       rebuild_memory;
    logic       text_colors_changed;
    logic       border_changed;
  } vms_result_t;

  typedef struct packed {
    logic [6:0] switches;
    logic [2:0] new_video;
    logic [3:0] text_fg;
    logic [3:0] text_bg;
    logic [7:0] border;
    logic [7:0] irq_status;
    logic [1:0] irq_enables;
    logic [3:0] cur_mode;
  } vms_state_t;

  localparam vms_state_t STATE_RESET = '{
    switches:    7'h04,
    new_video:   3'h0,
    text_fg:     4'hF,
    text_bg:     4'h0,
    border:      8'h00,
    irq_status:  8'h00,
    irq_enables: 2'h0,
    cur_mode:    DM_40TEXT1
  };

endpackage

@@ rtl/video_mode_switch_registers_core.sv @@
// ----------------------------------------------------------------------------
// video_mode_switch_registers_core
// Video soft-switch and register block with an input and a result register.
// ----------------------------------------------------------------------------
// Each request is one bus access to the video switches and registers and
// yields exactly one result. A request is taken into an input register, and
// on its way to the result register it is decoded against the held switch,
// colour, interrupt and mode registers, which the same decode also updates.
// One request is taken per cycle while in_stall is low, and its result goes
// from the input register to the result register, which lets the next request
// enter while a result still waits; only a stalled result holds the input side back.
module video_mode_switch_registers_core import vms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [5:0] mode,
  input  logic [7:0] write_data,
  input  logic       store80,
  input  logic [8:0] vert_count,
  input  logic [6:0] horiz_sample,
  input  logic [1:0] irq_events,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic [3:0] display_mode,
  output logic [2:0] page_move,
  output logic       full_redraw,
  output logic [1:0] geometry_change,
  output logic [1:0] irq_acks,
  output logic       rebuild_memory,
  output logic       text_colors_changed,
  output logic       border_changed
);

  logic        s1_valid;
  vms_item_t   s1_item;
  logic        s1_move;
  vms_state_t  state;
  vms_state_t  state_next;
  vms_result_t res_next;
  vms_result_t res;

  // The input stage moves on when the result register is free or draining.
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= '{mode: mode, write_data: write_data, store80: store80,
                   vert_count: vert_count, horiz_sample: horiz_sample,
                   irq_events: irq_events};
    end
  end

  // Access decode and register update.
  vms_access u_access (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_move) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res <= res_next;
    end
  end

  assign read_data           = res.read_data;
  assign display_mode        = res.display_mode;
  assign page_move           = res.page_move;
  assign full_redraw         = res.full_redraw;
  assign geometry_change     = res.geometry_change;
  assign irq_acks            = res.irq_acks;
  assign rebuild_memory      = res.rebuild_memory;
  assign text_colors_changed = res.text_colors_changed;
  assign border_changed      = res.border_changed;

endmodule

@@ rtl/vms_access.sv @@
// ----------------------------------------------------------------------------
// vms_access
// Decodes one access against the held registers and produces the next
// register values and the result of that access.
// ----------------------------------------------------------------------------
module vms_access import vms_pkg::*; (
  input  vms_state_t  cur,
  input  vms_item_t   item,
  output vms_state_t  nxt,
  output vms_result_t res
);

  logic       upd;
  logic       old_ok;
  logic [3:0] old_mode;
  logic [3:0] new_mode;
  logic [9:0] vert_sum;

  // Mode selection by the fixed priority tree.
  function automatic logic [3:0] pick_mode(input logic [6:0] sw, input logic [2:0] nv,
                                           input logic s80);
    logic       pg;
    logic       dbl;
    logic [3:0] m;
    pg  = !s80 && sw[SW_PAGE2];
    dbl = sw[SW_DBLRES] && sw[SW_80COL];
    if (nv[NV_SUPER]) begin
      m = DM_SUPER;
    end else if (sw[SW_TEXT]) begin
      m = (sw[SW_80COL] ? DM_80TEXT1 : DM_40TEXT1) | {3'b000, pg};
    end else if (sw[SW_HIRES]) begin
      m = (dbl ? DM_DHIRES1 : DM_HIRES1) | {3'b000, pg};
    end else begin
      m = (dbl ? DM_DLORES1 : DM_LORES1) | {3'b000, pg};
    end
    return m;
  endfunction

  assign vert_sum = {1'b0, item.vert_count} + VERT_OFFSET;

  always_comb begin
    nxt      = cur;
    res      = '0;
    upd      = 1'b0;
    old_ok   = 1'b1;
    old_mode = cur.cur_mode;

    // Interrupt sources land before the access itself.
    nxt.irq_status = cur.irq_status |
                     {item.irq_events[1] | item.irq_events[0], item.irq_events[0],
                      item.irq_events[1], 5'b00000};

    unique case (item.mode)
      ACC_CLR80COL, ACC_SET80COL: begin
        nxt.switches[SW_80COL] = (item.mode == ACC_SET80COL);
        upd = 1'b1;
      end
      ACC_RD80COL: res.read_data = {cur.switches[SW_80COL], 7'b0};
      ACC_CLRALTCH, ACC_SETALTCH: begin
        nxt.switches[SW_ALTCH] = (item.mode == ACC_SETALTCH);
        upd = 1'b1;
      end
      ACC_RDALTCH: res.read_data = {cur.switches[SW_ALTCH], 7'b0};
      ACC_RDCOLOR: res.read_data = {cur.text_fg, cur.text_bg};
      ACC_WRCOLOR: begin
        nxt.text_fg = item.write_data[7:4];
        nxt.text_bg = item.write_data[3:0];
        res.text_colors_changed = 1'b1;
      end
      ACC_RDINTREG: res.read_data = {nxt.irq_status[7:3], cur.irq_enables, 1'b0};
      ACC_WRINTREG: nxt.irq_enables = item.write_data[2:1];
      ACC_CLRINT: begin
        // Each cleared source that was pending counts as one acknowledge.
        res.irq_acks = {1'b0, !item.write_data[6] & nxt.irq_status[6]} +
                       {1'b0, !item.write_data[5] & nxt.irq_status[5]};
        if (!item.write_data[6]) nxt.irq_status[6] = 1'b0;
        if (!item.write_data[5]) nxt.irq_status[5] = 1'b0;
        if (nxt.irq_status[6:5] == 2'b00) nxt.irq_status[7] = 1'b0;
      end
      ACC_RDNEWVID: res.read_data = {cur.new_video[NV_SUPER], cur.new_video[NV_LINEAR],
                                     cur.new_video[NV_MONO], 5'b00001};
      ACC_WRNEWVID: begin
        nxt.new_video = {item.write_data[7], item.write_data[6], item.write_data[5]};
        upd = 1'b1;
      end
      ACC_RDVERTCNT: res.read_data = vert_sum[8:1];
      ACC_RDHORZCNT: res.read_data = {item.vert_count[0], item.horiz_sample};
      ACC_RDBORDER:  res.read_data = cur.border;
      ACC_WRBORDER: begin
        nxt.border         = item.write_data;
        res.border_changed = (cur.border != item.write_data);
      end
      ACC_CLRTEXT, ACC_SETTEXT: begin
        nxt.switches[SW_TEXT] = (item.mode == ACC_SETTEXT);
        upd = 1'b1;
      end
      ACC_RDTEXT: res.read_data = {cur.switches[SW_TEXT], 7'b0};
      ACC_CLRMIXED, ACC_SETMIXED: begin
        nxt.switches[SW_MIXED] = (item.mode == ACC_SETMIXED);
        upd = 1'b1;
      end
      ACC_RDMIXED: res.read_data = {cur.switches[SW_MIXED], 7'b0};
      ACC_CLRPAGE2, ACC_SETPAGE2: begin
        // With 80STORE set, page 2 remaps memory instead of the display.
        nxt.switches[SW_PAGE2] = (item.mode == ACC_SETPAGE2);
        res.rebuild_memory     = item.store80;
        upd                    = !item.store80;
      end
      ACC_RDPAGE2: res.read_data = {cur.switches[SW_PAGE2], 7'b0};
      ACC_CLRHIRES, ACC_SETHIRES: begin
        nxt.switches[SW_HIRES] = (item.mode == ACC_SETHIRES);
        upd = 1'b1;
      end
      ACC_RDHIRES: res.read_data = {cur.switches[SW_HIRES], 7'b0};
      ACC_CLRDBLRES, ACC_SETDBLRES: begin
        nxt.switches[SW_DBLRES] = (item.mode == ACC_SETDBLRES);
        upd = 1'b1;
      end
      ACC_VIDRESET: begin
        // Video reset keeps the enables and treats the old mode as super.
        nxt.irq_status = 8'h00;
        nxt.switches   = STATE_RESET.switches;
        nxt.new_video  = STATE_RESET.new_video;
        nxt.border     = STATE_RESET.border;
        nxt.text_bg    = STATE_RESET.text_bg;
        nxt.text_fg    = STATE_RESET.text_fg;
        old_mode       = DM_SUPER;
        upd            = 1'b1;
      end
      ACC_REDRAW: begin
        old_ok = 1'b0;
        upd    = 1'b1;
      end
      default: begin
      end
    endcase

    // Mode recompute and change report.
    new_mode = pick_mode(nxt.switches, nxt.new_video, item.store80);
    if (upd) begin
      nxt.cur_mode = new_mode;
      if (!old_ok || old_mode != new_mode) begin
        if (old_ok && old_mode == DM_HIRES1 && new_mode == DM_HIRES2) begin
          res.page_move = PM_HI_1TO2;
        end else if (old_ok && old_mode == DM_HIRES2 && new_mode == DM_HIRES1) begin
          res.page_move = PM_HI_2TO1;
        end else if (old_ok && old_mode == DM_DHIRES1 && new_mode == DM_DHIRES2) begin
          res.page_move = PM_DHI_1TO2;
        end else if (old_ok && old_mode == DM_DHIRES2 && new_mode == DM_DHIRES1) begin
          res.page_move = PM_DHI_2TO1;
        end else begin
          res.full_redraw = 1'b1;
          if (new_mode == DM_SUPER) begin
            res.geometry_change = GC_TO_SUPER;
          end else if (old_ok && old_mode == DM_SUPER) begin
            res.geometry_change = GC_TO_STD;
          end
        end
      end
    end

    res.display_mode = nxt.cur_mode;
  end

endmodule

@@ rtl/vms_checker.sv @@
// ----------------------------------------------------------------------------
// vms_checker
// Port-level checks for the video mode switch register block.
// ----------------------------------------------------------------------------
module vms_checker import vms_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] read_data,
  input logic [3:0] display_mode,
  input logic [2:0] page_move,
  input logic       full_redraw,
  input logic [1:0] geometry_change
);

  // A stalled result holds its fields.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) &&
      $stable(display_mode) && $stable(page_move) && $stable(full_redraw))
    else $error("stalled result changed");

  // The input side only stalls when a result is waiting on a stalled output.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A page move and a full redraw never come together.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(full_redraw && page_move != PM_NONE))
    else $error("page move reported with full redraw");

  // A geometry change is part of a full redraw, and it is a change to super exactly when the mode is super.
  a_geom: assert property (@(posedge clk) disable iff (rst)
    out_valid && geometry_change != GC_NONE |-> full_redraw &&
      ((geometry_change == GC_TO_SUPER) == (display_mode == DM_SUPER)))
    else $error("geometry change inconsistent with mode");

endmodule

bind video_mode_switch_registers_core vms_checker u_vms_checker (
  .clk             (clk),
  .rst             (rst),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .read_data       (read_data),
  .display_mode    (display_mode),
  .page_move       (page_move),
  .full_redraw     (full_redraw),
  .geometry_change (geometry_change)
);
